/* rtl/bsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// B-spline basis evaluator package
// Shared constants and widths for the span search and basis datapath.
// ----------------------------------------------------------------------------
package bsb_pkg;
    localparam int KNOT_DEPTH = 64;
    localparam int MAX_DEGREE = 7;
    localparam int KA_W = $clog2(KNOT_DEPTH);
    localparam int DEG_W = $clog2(MAX_DEGREE + 1);
    localparam int SEARCH_LIMIT = 16;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;
    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_KNOTS = 2'd1;
    localparam logic [1:0] CFG_TOL = 2'd2;

    function automatic logic [31:0] sat_q30(input logic signed [65:0] v);
        logic [31:0] r;
        if (v < 0) r = '0;
        else if (v > $signed({34'd0, Q30_ONE})) r = Q30_ONE;
        else r = v[31:0];
        return r;
    endfunction
endpackage

/* rtl/bsb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 34 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_num,
    input  logic [33:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_quo;
    logic [34:0] r_rem;
    logic [33:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [34:0] w_sh;

    assign w_sh = {r_rem[33:0], r_quo[63]};
    assign o_quo = r_quo;
    assign o_done = r_busy && (r_cnt == 7'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt <= 7'd64;
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (r_cnt == 7'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 7'd1;
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
            end
        end
    end
endmodule

/* rtl/bspline_span_and_basis_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// B-spline span and basis evaluator
// Knot memory, binary span search and Cox-de Boor recurrence.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// command   in         i_start and not o_busy
// config    in         i_cfg_we
// result    out        o_valid, one cycle, cannot stall
// A load writes one knot and returns to idle. An evaluation reads knots for the
// end shortcuts, runs binary search probes (at most 17), tests the span, reads
// the knots for each degree step and runs p(p+1)/2 recurrence steps of up to
// two divisions each through one shared divider, then emits p+1 results.
// Synchronous reset idles control and sets degree 3, 8 knots and zero
// tolerance; knots are undefined.
module bspline_span_and_basis_eval (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_cmd,
    input  logic [5:0]               i_knot_index,
    input  logic [31:0]              i_knot_value,
    input  logic [31:0]              i_param,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    output logic                     o_valid,
    output logic [5:0]               o_span,
    output logic [2:0]               o_basis_index,
    output logic [30:0]              o_basis_value,
    output logic                     o_last
);
    import bsb_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0,  S_RDLAST = 5'd1, S_GLAST = 5'd2,
                           S_RDN1 = 5'd3,  S_GN1 = 5'd4,    S_RDP = 5'd5,
                           S_GP = 5'd6,    S_RDM = 5'd7,    S_GM = 5'd8,
                           S_RDM1 = 5'd9,  S_GM1 = 5'd10,   S_RDS = 5'd11,
                           S_GS = 5'd12,   S_RDS1 = 5'd13,  S_GS1 = 5'd14,
                           S_JRL = 5'd15,  S_JGL = 5'd16,   S_JRR = 5'd17,
                           S_JGR = 5'd18,  S_RA = 5'd19,    S_WA = 5'd20,
                           S_WB = 5'd21,   S_OUT = 5'd22,   S_LOAD = 5'd23;

    logic [31:0] r_mem [KNOT_DEPTH];
    logic [31:0] r_rd;
    logic [KA_W-1:0] r_addr;
    logic        r_rd_ok;

    logic [4:0]  r_st;
    logic [2:0]  r_deg;
    logic [6:0]  r_kc;
    logic [15:0] r_tol;
    logic [2:0]  r_p;
    logic [6:0]  r_k, r_n;
    logic [33:0] r_u;
    logic [6:0]  r_lo, r_hi, r_mid, r_span;
    logic [4:0]  r_steps;
    logic signed [33:0] r_ka;
    logic [2:0]  r_j, r_r;
    logic signed [33:0] r_left [MAX_DEGREE+1];
    logic signed [33:0] r_right [MAX_DEGREE+1];
    logic [31:0] r_basis [MAX_DEGREE+1];
    logic [31:0] r_saved, r_qa;
    logic        r_go;
    logic [63:0] r_num;
    logic [33:0] r_den;
    logic [2:0]  r_oi;

    logic        w_done;
    logic [63:0] w_quo;
    logic [6:0]  w_rda;
    logic        w_rde;
    logic signed [33:0] w_kv, w_lo_t, w_hi_t, w_rd, w_ld, w_den;
    logic [33:0] w_rd_mag, w_ld_mag, w_den_mag;
    logic        w_neg_a, w_neg_b;
    logic [31:0] w_qb;
    logic [2:0]  w_pc;
    logic [6:0]  w_kc;
    logic [31:0] w_sum;

    bsb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_go), .i_num(r_num),
                   .i_den(r_den), .o_done(w_done), .o_quo(w_quo));

    assign w_kv = r_rd_ok ? $signed({2'b00, r_rd}) : 34'sd0;
    assign w_lo_t = r_ka - $signed({18'd0, r_tol});
    assign w_hi_t = w_kv - $signed({18'd0, r_tol});
    assign w_pc = (r_deg == 3'd0) ? 3'd1 : r_deg;
    assign w_kc = (r_kc > 7'(KNOT_DEPTH)) ? 7'(KNOT_DEPTH) : r_kc;
    assign w_rd = r_right[r_r + 3'd1];
    assign w_ld = r_left[r_j - r_r];
    assign w_den = w_rd + w_ld;
    assign w_rd_mag = w_rd[33] ? -w_rd : w_rd;
    assign w_ld_mag = w_ld[33] ? -w_ld : w_ld;
    assign w_den_mag = w_den[33] ? -w_den : w_den;
    assign w_neg_a = w_rd[33] ^ w_den[33];
    assign w_neg_b = w_ld[33] ^ w_den[33];
    assign w_qb = w_neg_b ? 32'd0 : sat_q30({2'b00, w_quo});
    assign w_sum = sat_q30($signed({34'd0, r_saved}) + $signed({34'd0, r_qa}));

    always_comb begin
        w_rda = r_mid;
        w_rde = 1'b0;
        case (r_st)
            S_RDLAST: begin w_rda = r_k - 7'd1; w_rde = 1'b1; end
            S_RDN1:   begin w_rda = r_n + 7'd1; w_rde = 1'b1; end
            S_RDP:    begin w_rda = {4'd0, r_p}; w_rde = 1'b1; end
            S_RDM:    begin w_rda = r_mid; w_rde = 1'b1; end
            S_RDM1:   begin w_rda = r_mid + 7'd1; w_rde = 1'b1; end
            S_RDS:    begin w_rda = r_span; w_rde = 1'b1; end
            S_RDS1:   begin w_rda = r_span + 7'd1; w_rde = 1'b1; end
            S_JRL:    begin w_rda = r_span + 7'd1 - {4'd0, r_j}; w_rde = 1'b1; end
            S_JRR:    begin w_rda = r_span + {4'd0, r_j}; w_rde = 1'b1; end
            default:  begin w_rda = r_mid; w_rde = 1'b0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_LOAD) begin
            r_mem[r_addr] <= r_num[31:0];
        end
        if (w_rde) begin
            r_rd <= r_mem[w_rda[KA_W-1:0]];
            r_rd_ok <= (w_rda < 7'(KNOT_DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_deg <= 3'd3;
            r_kc <= 7'd8;
            r_tol <= '0;
            r_go <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEGREE: r_deg <= i_cfg_data[2:0];
                    CFG_KNOTS:  r_kc <= i_cfg_data[6:0];
                    CFG_TOL:    r_tol <= i_cfg_data;
                    default:    r_tol <= r_tol;
                endcase
            end
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_cmd == CMD_LOAD) begin
                            r_addr <= i_knot_index[KA_W-1:0];
                            r_num <= {32'd0, i_knot_value};
                            r_st <= S_LOAD;
                        end else begin
                            r_p <= w_pc;
                            r_k <= (w_kc < {3'd0, w_pc, 1'b0} + 7'd2) ?
                                   {3'd0, w_pc, 1'b0} + 7'd2 : w_kc;
                            r_u <= {2'b00, i_param};
                            r_st <= S_RDLAST;
                        end
                    end
                end
                S_LOAD: r_st <= S_IDLE;
                S_RDLAST: begin
                    r_n <= r_k - {4'd0, r_p} - 7'd2;
                    r_st <= S_GLAST;
                end
                S_GLAST: begin
                    if ($signed(r_u) > w_kv) r_u <= w_kv;
                    r_st <= S_RDN1;
                end
                S_RDN1: r_st <= S_GN1;
                S_GN1: begin
                    if ($signed(r_u) >= w_hi_t) begin
                        r_span <= r_n;
                        r_st <= S_RDS;
                    end else r_st <= S_RDP;
                end
                S_RDP: r_st <= S_GP;
                S_GP: begin
                    if ($signed(r_u) <= w_kv + $signed({18'd0, r_tol})) begin
                        r_span <= {4'd0, r_p};
                        r_st <= S_RDS;
                    end else begin
                        r_lo <= {4'd0, r_p};
                        r_hi <= r_n + 7'd1;
                        r_mid <= 7'(({1'b0, 4'd0, r_p} + {1'b0, r_n} + 8'd1) >> 1);
                        r_steps <= '0;
                        r_st <= S_RDM;
                    end
                end
                S_RDM: r_st <= S_GM;
                S_GM: begin
                    r_ka <= w_kv;
                    r_st <= S_RDM1;
                end
                S_RDM1: r_st <= S_GM1;
                S_GM1: begin
                    if (r_steps < 5'(SEARCH_LIMIT) && r_lo < r_hi &&
                        ($signed(r_u) < w_lo_t || $signed(r_u) >= w_hi_t)) begin
                        if ($signed(r_u) < w_lo_t) begin
                            r_hi <= r_mid;
                            r_mid <= 7'(({1'b0, r_lo} + {1'b0, r_mid}) >> 1);
                        end else begin
                            r_lo <= r_mid;
                            r_mid <= 7'(({1'b0, r_mid} + {1'b0, r_hi}) >> 1);
                        end
                        r_steps <= r_steps + 5'd1;
                        r_st <= S_RDM;
                    end else begin
                        r_span <= r_mid;
                        r_st <= S_RDS;
                    end
                end
                S_RDS: r_st <= S_GS;
                S_GS: begin
                    r_ka <= w_kv;
                    r_st <= S_RDS1;
                end
                S_RDS1: r_st <= S_GS1;
                S_GS1: begin
                    r_basis[0] <= (r_span >= r_n || ($signed(r_u) >= w_lo_t &&
                                   $signed(r_u) < w_hi_t)) ? Q30_ONE : 32'd0;
                    r_j <= 3'd1;
                    r_st <= S_JRL;
                end
                S_JRL: r_st <= S_JGL;
                S_JGL: begin
                    r_left[r_j] <= $signed(r_u) - w_kv;
                    r_st <= S_JRR;
                end
                S_JRR: r_st <= S_JGR;
                S_JGR: begin
                    r_right[r_j] <= w_kv - $signed(r_u);
                    r_r <= '0;
                    r_saved <= '0;
                    r_st <= S_RA;
                end
                S_RA: begin
                    if (w_den == 0) begin
                        r_basis[r_r] <= r_saved;
                        r_saved <= '0;
                        if (r_r + 3'd1 == r_j) begin
                            r_basis[r_j] <= '0;
                            if (r_j == r_p) begin r_oi <= '0; r_st <= S_OUT; end
                            else begin r_j <= r_j + 3'd1; r_st <= S_JRL; end
                        end else r_r <= r_r + 3'd1;
                    end else begin
                        r_num <= {32'd0, w_rd_mag[31:0]} * {32'd0, r_basis[r_r]};
                        r_den <= w_den_mag;
                        r_go <= 1'b1;
                        r_st <= S_WA;
                    end
                end
                S_WA: begin
                    if (w_done) begin
                        r_qa <= w_neg_a ? 32'd0 : sat_q30({2'b00, w_quo});
                        r_num <= {32'd0, w_ld_mag[31:0]} * {32'd0, r_basis[r_r]};
                        r_go <= 1'b1;
                        r_st <= S_WB;
                    end
                end
                S_WB: begin
                    if (w_done) begin
                        r_basis[r_r] <= w_sum;
                        r_saved <= w_qb;
                        if (r_r + 3'd1 == r_j) begin
                            r_basis[r_j] <= w_qb;
                            if (r_j == r_p) begin r_oi <= '0; r_st <= S_OUT; end
                            else begin r_j <= r_j + 3'd1; r_st <= S_JRL; end
                        end else begin
                            r_r <= r_r + 3'd1;
                            r_st <= S_RA;
                        end
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_span <= r_span[5:0];
                    o_basis_index <= r_oi;
                    o_basis_value <= r_basis[r_oi][30:0];
                    o_last <= (r_oi == r_p);
                    if (r_oi == r_p) r_st <= S_IDLE;
                    else r_oi <= r_oi + 3'd1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != S_IDLE);
endmodule
